FILE: rtl/modem_reply_stream_parser_unit_defines.svh
// Assertion macros shared by the modem reply stream parser RTL.
// No dependencies; the including module must have clock and reset in scope.
`ifndef MODEM_REPLY_STREAM_PARSER_UNIT_DEFINES_SVH
`define MODEM_REPLY_STREAM_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MRSP_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define MRSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mrsp_pkg.sv
// Types and constants for the modem reply stream parser.
// No dependencies.
package mrsp_pkg;

   // Command codes of an input item.
   typedef enum logic [1:0] {
      CMD_BYTE  = 2'd0,
      CMD_LINE  = 2'd1,
      CMD_ACK   = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   // Parser modes, also reported on the result channel.
   typedef enum logic [2:0] {
      MODE_LINE    = 3'd0,
      MODE_ACKLEN  = 3'd1,
      MODE_PAYLEN  = 3'd2,
      MODE_TYPE    = 3'd3,
      MODE_PAYLOAD = 3'd4,
      MODE_DONE    = 3'd5
   } mode_type;

   // Bit positions in the reply flag vector.
   localparam int unsigned FLAG_OK        = 0;
   localparam int unsigned FLAG_ERROR     = 1;
   localparam int unsigned FLAG_NOCARRIER = 2;
   localparam int unsigned FLAG_CONNECT   = 3;
   localparam int unsigned FLAG_BYTE      = 4;
   localparam int unsigned FLAG_COUNT     = 5;

   // Characters of interest.
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_NUL  = 8'h00;
   localparam logic [7:0] CHAR_O    = 8'h4F;
   localparam logic [7:0] CHAR_K    = 8'h4B;
   localparam logic [7:0] CHAR_E    = 8'h45;
   localparam logic [7:0] CHAR_R    = 8'h52;
   localparam logic [7:0] CHAR_N    = 8'h4E;
   localparam logic [7:0] CHAR_C    = 8'h43;

   // Length coding: 7 data bits per group, bit 7 flags more groups.
   localparam int unsigned GROUP_BITS = 7;
   localparam int unsigned MORE_BIT   = 7;

endpackage

FILE: rtl/modem_reply_stream_parser_unit.sv
// Receive parser for a modem link: reply line flags and packet length decode.
// Depends on mrsp_pkg and modem_reply_stream_parser_unit_defines.svh.
//
// Usage:
//    The req channel carries one item per handshake: a command (received byte,
//    enter line mode, enter acknowledge mode, clear flags) and a data byte.
//    The rsp channel returns exactly one result item per request item, showing
//    the mode, flags, lengths and type after that item, plus the payload byte
//    and its index when the item was a payload byte.
//    An item is taken at a clock edge where valid is high and stall is low.
//    Each item lands in the input register, then the parse logic updates the
//    state and fills the result register.
//    Throughput is one item per cycle while the receiver does not stall; the
//    only loop is the parser state register, updated once per item by a single
//    shift-or, increment and compare.
//    When the receiver stalls, the result register holds; the input register
//    takes one more item if it is empty, then req_stall is raised.
//    Synchronous reset returns the parser to line mode with all flags, lengths,
//    counts and characters cleared, and empties both registers.
`include "modem_reply_stream_parser_unit_defines.svh"

module modem_reply_stream_parser_unit (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_data_byte,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_mode,
   output logic        rsp_ok_seen,
   output logic        rsp_error_seen,
   output logic        rsp_no_carrier_seen,
   output logic        rsp_connect_seen,
   output logic        rsp_byte_seen,
   output logic [31:0] rsp_ack_length,
   output logic [7:0]  rsp_packet_type,
   output logic [7:0]  rsp_payload_byte,
   output logic [31:0] rsp_payload_index,
   output logic        rsp_payload_valid,
   output logic        rsp_payload_last
);

   // Handshake control
   logic                req_accept;
   logic                out_ready;
   logic                advance;

   // Input register
   logic                in_valid_ff;
   logic                in_valid_in;
   mrsp_pkg::cmd_type   in_cmd_ff;
   logic [7:0]          in_data_ff;

   // Parser state
   mrsp_pkg::mode_type  mode_ff, mode_in;
   logic [mrsp_pkg::FLAG_COUNT-1:0] flags_ff, flags_in;
   logic [31:0]         acc_ff, acc_in;
   logic [31:0]         ack_ff, ack_in;
   logic [31:0]         count_ff, count_in;
   logic [7:0]          first_ff, first_in;
   logic [7:0]          second_ff, second_in;
   logic [7:0]          type_ff, type_in;

   // Per-item payload values
   logic                pv_in;
   logic                plast_in;
   logic [7:0]          pbyte_in;
   logic [31:0]         pidx_in;

   // Helpers
   logic [31:0]         count_inc;
   logic [31:0]         acc_shifted;
   logic [7:0]          line_a;
   logic [7:0]          line_b;

   // Result register
   logic                out_valid_ff;
   logic                out_valid_in;
   logic [2:0]          out_mode_ff;
   logic [mrsp_pkg::FLAG_COUNT-1:0] out_flags_ff;
   logic [31:0]         out_ack_ff;
   logic [7:0]          out_type_ff;
   logic [7:0]          out_pbyte_ff;
   logic [31:0]         out_pidx_ff;
   logic                out_pv_ff;
   logic                out_plast_ff;

   // Handshake: the result register frees when empty or being taken.
   assign out_ready  = !out_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_ready;
   assign req_stall  = in_valid_ff && !out_ready;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_stall ? 1'b0 : out_valid_ff);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_accept) begin
         in_cmd_ff  <= mrsp_pkg::cmd_type'(req_cmd);
         in_data_ff <= req_data_byte;
      end
   end

   // Shared arithmetic for the parse step.
   assign count_inc   = count_ff + 32'd1;
   assign acc_shifted = {acc_ff[31-mrsp_pkg::GROUP_BITS:0],
                         in_data_ff[mrsp_pkg::GROUP_BITS-1:0]};
   // Character positions not yet received in the line read as zero.
   assign line_a = (count_ff != 32'd0) ? first_ff : mrsp_pkg::CHAR_NUL;
   assign line_b = (count_ff > 32'd1) ? second_ff : mrsp_pkg::CHAR_NUL;

   // Next parser state and payload fields for the item in the input register.
   always_comb begin
      mode_in   = mode_ff;
      flags_in  = flags_ff;
      acc_in    = acc_ff;
      ack_in    = ack_ff;
      count_in  = count_ff;
      first_in  = first_ff;
      second_in = second_ff;
      type_in   = type_ff;
      pv_in     = 1'b0;
      plast_in  = 1'b0;
      pbyte_in  = 8'd0;
      pidx_in   = 32'd0;
      unique case (in_cmd_ff)
         mrsp_pkg::CMD_LINE: begin
            mode_in  = mrsp_pkg::MODE_LINE;
            count_in = 32'd0;
         end
         mrsp_pkg::CMD_ACK: begin
            mode_in = mrsp_pkg::MODE_ACKLEN;
            acc_in  = 32'd0;
            ack_in  = 32'd0;
         end
         mrsp_pkg::CMD_CLEAR: begin
            flags_in = '0;
         end
         mrsp_pkg::CMD_BYTE: begin
            flags_in[mrsp_pkg::FLAG_BYTE] = 1'b1;
            unique case (mode_ff)
               mrsp_pkg::MODE_LINE: begin
                  if (in_data_ff == mrsp_pkg::CHAR_CR) begin
                     // End of reply line: match on the first two characters.
                     if (line_a == mrsp_pkg::CHAR_O && line_b == mrsp_pkg::CHAR_K) begin
                        flags_in[mrsp_pkg::FLAG_OK] = 1'b1;
                     end else if (line_a == mrsp_pkg::CHAR_E &&
                                  line_b == mrsp_pkg::CHAR_R) begin
                        flags_in[mrsp_pkg::FLAG_ERROR] = 1'b1;
                     end else if (line_a == mrsp_pkg::CHAR_N &&
                                  line_b == mrsp_pkg::CHAR_O) begin
                        flags_in[mrsp_pkg::FLAG_NOCARRIER] = 1'b1;
                     end else if (line_a == mrsp_pkg::CHAR_C &&
                                  line_b == mrsp_pkg::CHAR_O) begin
                        flags_in[mrsp_pkg::FLAG_CONNECT] = 1'b1;
                     end
                     count_in = 32'd0;
                  end else if (in_data_ff != mrsp_pkg::CHAR_LF &&
                               in_data_ff != mrsp_pkg::CHAR_NUL) begin
                     if (count_ff == 32'd0) begin
                        first_in = in_data_ff;
                     end else if (count_ff == 32'd1) begin
                        second_in = in_data_ff;
                     end
                     // The line count saturates.
                     if (count_ff != '1) begin
                        count_in = count_inc;
                     end
                  end
               end
               mrsp_pkg::MODE_ACKLEN: begin
                  if (!in_data_ff[mrsp_pkg::MORE_BIT]) begin
                     mode_in = mrsp_pkg::MODE_PAYLEN;
                     ack_in  = acc_shifted;
                     acc_in  = 32'd0;
                  end else begin
                     acc_in = acc_shifted;
                  end
               end
               mrsp_pkg::MODE_PAYLEN: begin
                  acc_in = acc_shifted;
                  if (!in_data_ff[mrsp_pkg::MORE_BIT]) begin
                     mode_in = mrsp_pkg::MODE_TYPE;
                  end
               end
               mrsp_pkg::MODE_TYPE: begin
                  type_in  = in_data_ff;
                  count_in = 32'd0;
                  // A zero payload length skips the payload phase.
                  mode_in  = (acc_ff == 32'd0) ? mrsp_pkg::MODE_DONE
                                               : mrsp_pkg::MODE_PAYLOAD;
               end
               mrsp_pkg::MODE_PAYLOAD: begin
                  pv_in    = 1'b1;
                  pbyte_in = in_data_ff;
                  pidx_in  = count_ff;
                  count_in = count_inc;
                  if (count_inc == acc_ff) begin
                     plast_in = 1'b1;
                     mode_in  = mrsp_pkg::MODE_DONE;
                  end
               end
               default: begin
                  // Done mode and unused codes ignore the byte.
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // Parser state register, updated once per item.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= mrsp_pkg::MODE_LINE;
         flags_ff  <= '0;
         acc_ff    <= 32'd0;
         ack_ff    <= 32'd0;
         count_ff  <= 32'd0;
         first_ff  <= 8'd0;
         second_ff <= 8'd0;
         type_ff   <= 8'd0;
      end else if (advance) begin
         mode_ff   <= mode_in;
         flags_ff  <= flags_in;
         acc_ff    <= acc_in;
         ack_ff    <= ack_in;
         count_ff  <= count_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         type_ff   <= type_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         out_mode_ff  <= mode_in;
         out_flags_ff <= flags_in;
         out_ack_ff   <= ack_in;
         out_type_ff  <= type_in;
         out_pbyte_ff <= pbyte_in;
         out_pidx_ff  <= pidx_in;
         out_pv_ff    <= pv_in;
         out_plast_ff <= plast_in;
      end
   end

   // Result ports.
   assign rsp_valid           = out_valid_ff;
   assign rsp_mode            = out_mode_ff;
   assign rsp_ok_seen         = out_flags_ff[mrsp_pkg::FLAG_OK];
   assign rsp_error_seen      = out_flags_ff[mrsp_pkg::FLAG_ERROR];
   assign rsp_no_carrier_seen = out_flags_ff[mrsp_pkg::FLAG_NOCARRIER];
   assign rsp_connect_seen    = out_flags_ff[mrsp_pkg::FLAG_CONNECT];
   assign rsp_byte_seen       = out_flags_ff[mrsp_pkg::FLAG_BYTE];
   assign rsp_ack_length      = out_ack_ff;
   assign rsp_packet_type     = out_type_ff;
   assign rsp_payload_byte    = out_pbyte_ff;
   assign rsp_payload_index   = out_pidx_ff;
   assign rsp_payload_valid   = out_pv_ff;
   assign rsp_payload_last    = out_plast_ff;

   // Checks on the parse logic and the two-register handoff.
   `MRSP_ASSERT_IMPLIES(a_payload_mode,
      out_valid_ff && out_pv_ff,
      out_mode_ff == mrsp_pkg::MODE_PAYLOAD || out_mode_ff == mrsp_pkg::MODE_DONE,
      "Payload byte reported outside payload or done mode.")
   `MRSP_ASSERT_IMPLIES(a_last_done,
      out_valid_ff && out_plast_ff,
      out_pv_ff && out_mode_ff == mrsp_pkg::MODE_DONE,
      "Last payload byte did not move the parser to done mode.")
   `MRSP_ASSERT_IMPLIES(a_idle_payload_zero,
      out_valid_ff && !out_pv_ff,
      out_pidx_ff == 32'd0 && out_pbyte_ff == 8'd0 && !out_plast_ff,
      "Payload fields not zero on an item without a payload byte.")
   `MRSP_ASSERT_NEXT(a_input_held,
      in_valid_ff && !out_ready,
      in_valid_ff && $stable(in_data_ff) && $stable(in_cmd_ff),
      "Item in the input register lost while the result register was full.")

endmodule

FILE: tb/tb_modem_reply_stream_parser_unit.sv
// Self-checking testbench for the modem reply stream parser: directed and random items
// with random idling on both channels, checked against a predictor in a scoreboard class.
// Depends on mrsp_pkg and the modem_reply_stream_parser_unit RTL.
`timescale 1ns / 100ps

module tb_modem_reply_stream_parser_unit;

   // Cycles without any handshake before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;
   // Cycles to keep watching after the last expected result.
   localparam int TAIL_CYCLES    = 20;
   localparam int RANDOM_ITEMS   = 1400;

   // One result item, fields in port order.
   typedef struct packed {
      mrsp_pkg::mode_type mode;
      logic        ok;
      logic        error;
      logic        no_carrier;
      logic        connect;
      logic        byte_seen;
      logic [31:0] ack_length;
      logic [7:0]  packet_type;
      logic [7:0]  payload_byte;
      logic [31:0] payload_index;
      logic        payload_valid;
      logic        payload_last;
   } parse_result_type;

   // Tracks the parser state and holds the results still to come.
   class reply_tracker_type;
      mrsp_pkg::mode_type mode;
      logic [4:0]    flags;
      logic [31:0]   length_acc;
      logic [31:0]   ack_len;
      logic [31:0]   line_count;
      logic [7:0]    first_char;
      logic [7:0]    second_char;
      logic [7:0]    ptype;
      parse_result_type expected_replies[$];
      int            errors;

      function new();
         mode        = mrsp_pkg::MODE_LINE;
         flags       = '0;
         length_acc  = '0;
         ack_len     = '0;
         line_count  = '0;
         first_char  = '0;
         second_char = '0;
         ptype       = '0;
         errors      = 0;
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      // Advances the parser state by one accepted item and queues its result.
      function void note_item(mrsp_pkg::cmd_type c, logic [7:0] d);
         parse_result_type r;
         logic [7:0]    a;
         logic [7:0]    b;
         r = '0;
         case (c)
            mrsp_pkg::CMD_LINE: begin
               mode       = mrsp_pkg::MODE_LINE;
               line_count = '0;
            end
            mrsp_pkg::CMD_ACK: begin
               mode       = mrsp_pkg::MODE_ACKLEN;
               length_acc = '0;
               ack_len    = '0;
            end
            mrsp_pkg::CMD_CLEAR: flags = '0;
            mrsp_pkg::CMD_BYTE: begin
               flags[mrsp_pkg::FLAG_BYTE] = 1'b1;
               case (mode)
                  mrsp_pkg::MODE_LINE: begin
                     if (d == mrsp_pkg::CHAR_CR) begin
                        // Positions never received in the line count as zero.
                        a = (line_count >= 1) ? first_char : mrsp_pkg::CHAR_NUL;
                        b = (line_count >= 2) ? second_char : mrsp_pkg::CHAR_NUL;
                        if (a == mrsp_pkg::CHAR_O && b == mrsp_pkg::CHAR_K) begin
                           flags[mrsp_pkg::FLAG_OK] = 1'b1;
                        end else if (a == mrsp_pkg::CHAR_E && b == mrsp_pkg::CHAR_R) begin
                           flags[mrsp_pkg::FLAG_ERROR] = 1'b1;
                        end else if (a == mrsp_pkg::CHAR_N && b == mrsp_pkg::CHAR_O) begin
                           flags[mrsp_pkg::FLAG_NOCARRIER] = 1'b1;
                        end else if (a == mrsp_pkg::CHAR_C && b == mrsp_pkg::CHAR_O) begin
                           flags[mrsp_pkg::FLAG_CONNECT] = 1'b1;
                        end
                        line_count = '0;
                     end else if (d != mrsp_pkg::CHAR_LF && d != mrsp_pkg::CHAR_NUL) begin
                        if (line_count == 0) first_char = d;
                        else if (line_count == 1) second_char = d;
                        if (line_count != '1) line_count++;
                     end
                  end
                  mrsp_pkg::MODE_ACKLEN: begin
                     length_acc = {length_acc[24:0], d[6:0]};
                     if (!d[mrsp_pkg::MORE_BIT]) begin
                        mode       = mrsp_pkg::MODE_PAYLEN;
                        ack_len    = length_acc;
                        length_acc = '0;
                     end
                  end
                  mrsp_pkg::MODE_PAYLEN: begin
                     length_acc = {length_acc[24:0], d[6:0]};
                     if (!d[mrsp_pkg::MORE_BIT]) mode = mrsp_pkg::MODE_TYPE;
                  end
                  mrsp_pkg::MODE_TYPE: begin
                     ptype      = d;
                     line_count = '0;
                     mode       = (length_acc == 0) ? mrsp_pkg::MODE_DONE
                                                    : mrsp_pkg::MODE_PAYLOAD;
                  end
                  mrsp_pkg::MODE_PAYLOAD: begin
                     r.payload_valid = 1'b1;
                     r.payload_byte  = d;
                     r.payload_index = line_count;
                     line_count++;
                     if (line_count == length_acc) begin
                        r.payload_last = 1'b1;
                        mode           = mrsp_pkg::MODE_DONE;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
         r.mode        = mode;
         r.ok          = flags[mrsp_pkg::FLAG_OK];
         r.error       = flags[mrsp_pkg::FLAG_ERROR];
         r.no_carrier  = flags[mrsp_pkg::FLAG_NOCARRIER];
         r.connect     = flags[mrsp_pkg::FLAG_CONNECT];
         r.byte_seen   = flags[mrsp_pkg::FLAG_BYTE];
         r.ack_length  = ack_len;
         r.packet_type = ptype;
         expected_replies.push_back(r);
      endfunction

      function int field_differs(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("time %0t: %s expected %0h, actual %0h", $time, name, want, got);
            return 1;
         end
         return 0;
      endfunction

      // Compares one accepted result with the oldest expectation.
      function void check_reply(parse_result_type got);
         parse_result_type want;
         int            bad;
         if (expected_replies.size() == 0) begin
            $display("time %0t: result item with no item outstanding, actual %h",
                     $time, got);
            errors++;
            return;
         end
         want = expected_replies.pop_front();
         bad  = 0;
         bad += field_differs("mode", want.mode, got.mode);
         bad += field_differs("ok_seen", want.ok, got.ok);
         bad += field_differs("error_seen", want.error, got.error);
         bad += field_differs("no_carrier_seen", want.no_carrier, got.no_carrier);
         bad += field_differs("connect_seen", want.connect, got.connect);
         bad += field_differs("byte_seen", want.byte_seen, got.byte_seen);
         bad += field_differs("ack_length", want.ack_length, got.ack_length);
         bad += field_differs("packet_type", want.packet_type, got.packet_type);
         bad += field_differs("payload_byte", want.payload_byte, got.payload_byte);
         bad += field_differs("payload_index", want.payload_index, got.payload_index);
         bad += field_differs("payload_valid", want.payload_valid, got.payload_valid);
         bad += field_differs("payload_last", want.payload_last, got.payload_last);
         if (bad != 0) errors++;
      endfunction
   endclass

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd       = mrsp_pkg::CMD_BYTE;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [2:0]  rsp_mode;
   logic        rsp_ok_seen;
   logic        rsp_error_seen;
   logic        rsp_no_carrier_seen;
   logic        rsp_connect_seen;
   logic        rsp_byte_seen;
   logic [31:0] rsp_ack_length;
   logic [7:0]  rsp_packet_type;
   logic [7:0]  rsp_payload_byte;
   logic [31:0] rsp_payload_index;
   logic        rsp_payload_valid;
   logic        rsp_payload_last;

   reply_tracker_type tracker = new();
   parse_result_type  seen_reply;
   int            quiet_cycles = 0;
   int            items_sent   = 0;
   int            send_gap_max = 0;
   int            stall_max    = 0;

   modem_reply_stream_parser_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_mode            (rsp_mode),
      .rsp_ok_seen         (rsp_ok_seen),
      .rsp_error_seen      (rsp_error_seen),
      .rsp_no_carrier_seen (rsp_no_carrier_seen),
      .rsp_connect_seen    (rsp_connect_seen),
      .rsp_byte_seen       (rsp_byte_seen),
      .rsp_ack_length      (rsp_ack_length),
      .rsp_packet_type     (rsp_packet_type),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_payload_index   (rsp_payload_index),
      .rsp_payload_valid   (rsp_payload_valid),
      .rsp_payload_last    (rsp_payload_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Handshake monitor, result checker and hang watchdog.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_valid && !req_stall) begin
            tracker.note_item(mrsp_pkg::cmd_type'(req_cmd), req_data_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            seen_reply = {rsp_mode, rsp_ok_seen, rsp_error_seen, rsp_no_carrier_seen,
                          rsp_connect_seen, rsp_byte_seen, rsp_ack_length, rsp_packet_type,
                          rsp_payload_byte, rsp_payload_index, rsp_payload_valid,
                          rsp_payload_last};
            tracker.check_reply(seen_reply);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("time %0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   function automatic int draw_wait(int max_wait);
      return (max_wait == 0) ? 0 : $urandom_range(0, max_wait);
   endfunction

   // Result side: a random stall before each result item.
   initial begin
      int n;
      forever begin
         n = draw_wait(stall_max);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Drives one item after a random gap and returns right after its acceptance.
   task automatic send_item(mrsp_pkg::cmd_type c, logic [7:0] d);
      int gap;
      gap = draw_wait(send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= c;
      req_data_byte <= d;
      do @(posedge clock); while (!(req_valid && !req_stall));
      items_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(mrsp_pkg::CMD_BYTE, s[i]);
   endtask

   // Holds the sender off until every outstanding result has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic pick_idle_style();
      case ($urandom_range(0, 4))
         0: begin send_gap_max = 0;  stall_max = 0;  end
         1: begin send_gap_max = 18; stall_max = 18; end
         2: begin send_gap_max = 18; stall_max = 0;  end
         3: begin send_gap_max = 0;  stall_max = 18; end
         default: begin send_gap_max = 3; stall_max = 3; end
      endcase
   endtask

   // Characters that tend to form near matches of the reply words.
   function automatic logic [7:0] pick_line_char();
      case ($urandom_range(0, 9))
         0: return mrsp_pkg::CHAR_O;
         1: return mrsp_pkg::CHAR_K;
         2: return mrsp_pkg::CHAR_E;
         3: return mrsp_pkg::CHAR_R;
         4: return mrsp_pkg::CHAR_N;
         5: return mrsp_pkg::CHAR_C;
         6: return mrsp_pkg::CHAR_LF;
         7: return mrsp_pkg::CHAR_NUL;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // One reply line, usually well formed, ended by a carriage return.
   task automatic reply_line_seq();
      string words[4] = '{"OK", "ERROR", "NO CARRIER", "CONNECT"};
      int    kind;
      if ($urandom_range(0, 1) == 1) begin
         send_item(mrsp_pkg::CMD_LINE, 8'($urandom_range(0, 255)));
      end
      kind = $urandom_range(0, 5);
      if (kind < 4) begin
         send_text(words[kind]);
      end else begin
         repeat ($urandom_range(0, 4)) begin
            if (kind == 4) send_item(mrsp_pkg::CMD_BYTE, pick_line_char());
            else send_item(mrsp_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 19) == 0) begin
         send_item(mrsp_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
      end
      send_item(mrsp_pkg::CMD_BYTE, mrsp_pkg::CHAR_CR);
      if ($urandom_range(0, 1) == 1) send_item(mrsp_pkg::CMD_BYTE, mrsp_pkg::CHAR_LF);
   endtask

   // One packet header and payload; a few are cut short or carry odd lengths.
   task automatic packet_seq();
      int          groups;
      int          len;
      int          pick;
      int          count;
      logic [13:0] len_bits;
      send_item(mrsp_pkg::CMD_ACK, 8'($urandom_range(0, 255)));
      // Acknowledge length: up to six groups, so long ones wrap at 32 bits.
      groups = $urandom_range(1, 6);
      for (int g = 0; g < groups; g++)
         send_item(mrsp_pkg::CMD_BYTE, {(g != groups - 1), 7'($urandom_range(0, 127))});
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         // Random groups: the length may be huge or wrap, so the payload is cut off.
         groups = $urandom_range(1, 6);
         for (int g = 0; g < groups; g++)
            send_item(mrsp_pkg::CMD_BYTE, {(g != groups - 1), 7'($urandom_range(0, 127))});
         len = -1;
      end else begin
         if (pick < 75) len = $urandom_range(0, 12);
         else if (pick < 95) len = $urandom_range(13, 40);
         else len = $urandom_range(128, 200);
         len_bits = 14'(len);
         if ($urandom_range(0, 9) == 0) send_item(mrsp_pkg::CMD_BYTE, 8'h80);
         if (len >= 128) send_item(mrsp_pkg::CMD_BYTE, {1'b1, len_bits[13:7]});
         send_item(mrsp_pkg::CMD_BYTE, {1'b0, len_bits[6:0]});
      end
      send_item(mrsp_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
      if (len < 0) count = $urandom_range(0, 8);
      else if ($urandom_range(0, 9) == 0) count = $urandom_range(0, len);
      else count = len;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 49) == 0) begin
            send_item(mrsp_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
         end
         send_item(mrsp_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
      end
      // Stray bytes after the packet end.
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3))
            send_item(mrsp_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
   endtask

   // Stimulus.
   initial begin
      int next_style;
      bit drained;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part: each reply word, ignored characters, short and empty lines,
      // extreme length groups, a zero payload length and a byte in done.
      send_item(mrsp_pkg::CMD_CLEAR, 8'hFF);
      send_text("OK\r");
      send_text("E\nR\r");
      send_item(mrsp_pkg::CMD_BYTE, mrsp_pkg::CHAR_N);
      send_item(mrsp_pkg::CMD_BYTE, mrsp_pkg::CHAR_NUL);
      send_text("O\r");
      send_text("COX\r");
      send_text("O\r");
      send_item(mrsp_pkg::CMD_CLEAR, 8'h00);
      send_item(mrsp_pkg::CMD_BYTE, mrsp_pkg::CHAR_CR);
      send_item(mrsp_pkg::CMD_ACK, 8'hAA);
      send_item(mrsp_pkg::CMD_BYTE, 8'hFF);
      send_item(mrsp_pkg::CMD_BYTE, 8'h00);
      send_item(mrsp_pkg::CMD_BYTE, 8'h00);
      send_item(mrsp_pkg::CMD_BYTE, 8'hFF);
      send_item(mrsp_pkg::CMD_BYTE, 8'h00);
      send_item(mrsp_pkg::CMD_LINE, 8'h55);
      wait_for_drain();

      // Random part, with the idling style changed every stretch of items.
      items_sent = 0;
      next_style = 0;
      drained    = 1'b0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= next_style) begin
            pick_idle_style();
            next_style = items_sent + $urandom_range(80, 200);
         end
         if (!drained && items_sent >= RANDOM_ITEMS / 2) begin
            wait_for_drain();
            drained = 1'b1;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: reply_line_seq();
            4, 5, 6, 7: packet_seq();
            8: send_item(mrsp_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
            default:
               repeat ($urandom_range(1, 4))
                  send_item(mrsp_pkg::cmd_type'($urandom_range(0, 3)),
                            8'($urandom_range(0, 255)));
         endcase
      end

      // Let every result come back, then watch a little longer for strays.
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
